/* rtl/wbrm_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, word types and the storage request struct for the byte rate meter.
// Depends on nothing; every other file refers to it by scoped names.
package wbrm_pkg;

    localparam int CHANNELS = 64;
    localparam int WINDOW   = 30;

    localparam int OP_W     = 2;
    localparam int CH_W     = 6;
    localparam int TOT_W    = 48;
    localparam int DELTA_W  = 40;
    localparam int SUM_W    = 46;
    localparam int RATE_W   = 53;
    localparam int SIZE_W   = 26;
    localparam int UNIT_W   = 2;

    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int SLOT_ADR_W = CH_IDX_W + SLOT_W;
    localparam int SLOT_DEPTH = 2 ** SLOT_ADR_W;
    localparam int DIV_W      = SUM_W + 8;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    localparam logic [DIV_W-1:0] RATE_POS_MAX = DIV_W'((64'd1 << (RATE_W - 1)) - 64'd1);
    localparam logic [DIV_W-1:0] RATE_NEG_MAG = DIV_W'(64'd1 << (RATE_W - 1));

    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    localparam logic [UNIT_W-1:0] UNIT_B  = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_KB = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_MB = 2'd2;
    localparam logic [UNIT_W-1:0] UNIT_GB = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CH_W-1:0]  channel;
        logic [TOT_W-1:0] total_bytes;
    } t_in_word;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate_scaled;
        logic [UNIT_W-1:0]        rate_unit;
        logic [SIZE_W-1:0]        size_scaled;
        logic [UNIT_W-1:0]        size_unit;
    } t_out_word;

    typedef struct packed {
        logic                      ch_we;
        logic                      ch_re;
        logic [CH_IDX_W-1:0]       ch_addr;
        logic [TOT_W-1:0]          prev_wdata;
        logic signed [SUM_W-1:0]   sum_wdata;
        logic                      slot_we;
        logic                      slot_re;
        logic [SLOT_ADR_W-1:0]     slot_addr;
        logic signed [DELTA_W-1:0] slot_wdata;
    } t_store_req;

endpackage

/* rtl/wbrm_store.sv */
`timescale 1ns / 1ps
// Per-channel memories: previous total, window sum and window slots, registered reads.
// Depends on wbrm_pkg.
module wbrm_store (
    input  logic                               i_clk,
    input  wbrm_pkg::t_store_req               i_req,
    output logic [wbrm_pkg::TOT_W-1:0]         o_prev,
    output logic signed [wbrm_pkg::SUM_W-1:0]  o_sum,
    output logic signed [wbrm_pkg::DELTA_W-1:0] o_slot
);

    logic [wbrm_pkg::TOT_W-1:0]          r_prev_mem [wbrm_pkg::CHANNELS];
    logic signed [wbrm_pkg::SUM_W-1:0]   r_sum_mem  [wbrm_pkg::CHANNELS];
    logic signed [wbrm_pkg::DELTA_W-1:0] r_slot_mem [wbrm_pkg::SLOT_DEPTH];

    logic [wbrm_pkg::TOT_W-1:0]          r_prev_rd;
    logic signed [wbrm_pkg::SUM_W-1:0]   r_sum_rd;
    logic signed [wbrm_pkg::DELTA_W-1:0] r_slot_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.ch_we) begin
            r_prev_mem[i_req.ch_addr] <= i_req.prev_wdata;
            r_sum_mem[i_req.ch_addr]  <= i_req.sum_wdata;
        end
        if (i_req.ch_re) begin
            r_prev_rd <= r_prev_mem[i_req.ch_addr];
            r_sum_rd  <= r_sum_mem[i_req.ch_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.slot_we) begin
            r_slot_mem[i_req.slot_addr] <= i_req.slot_wdata;
        end
        if (i_req.slot_re) begin
            r_slot_rd <= r_slot_mem[i_req.slot_addr];
        end
    end

    assign o_prev = r_prev_rd;
    assign o_sum  = r_sum_rd;
    assign o_slot = r_slot_rd;

endmodule

/* rtl/wbrm_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the window average.
// Depends on wbrm_pkg.
module wbrm_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [wbrm_pkg::DIV_W-1:0]      i_dividend,
    input  logic [wbrm_pkg::FILL_W-1:0]     i_divisor,
    output logic                            o_done,
    output logic [wbrm_pkg::DIV_W-1:0]      o_quotient
);

    logic [wbrm_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_done;
    logic [wbrm_pkg::DIV_W-1:0]     r_dvd;
    logic [wbrm_pkg::FILL_W-1:0]    r_rem;
    logic [wbrm_pkg::FILL_W-1:0]    r_div;

    logic [wbrm_pkg::FILL_W:0]      n_rem_sh;
    logic [wbrm_pkg::FILL_W:0]      n_rem;
    logic                           n_qbit;

    always_comb begin
        n_rem_sh = {r_rem, r_dvd[wbrm_pkg::DIV_W-1]};
        n_qbit   = (n_rem_sh >= {1'b0, r_div});
        n_rem    = n_qbit ? (n_rem_sh - {1'b0, r_div}) : n_rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && (r_cnt == wbrm_pkg::DIV_CNT_W'(1));
            if (i_start) begin
                r_cnt <= wbrm_pkg::DIV_CNT_W'(wbrm_pkg::DIV_W);
                r_dvd <= i_dividend;
                r_rem <= '0;
                r_div <= i_divisor;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_dvd  <= {r_dvd[wbrm_pkg::DIV_W-2:0], n_qbit};
                r_rem  <= n_rem[wbrm_pkg::FILL_W-1:0];
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

/* rtl/windowed_byte_rate_meter.sv */
`timescale 1ns / 1ps
// Sample: after accept the states DELTA, SUM, ABS, UNIT, DIV and FINISH run before word valid;
// DIV is skipped with an empty window; the bit-serial divider makes one quotient bit per cycle
// over SUM_W + 8 bits; ready returns with valid. Start: SWEEP clears one window slot per cycle.
// The output register lets the next word be accepted while a result waits.
// After reset the block clears all CHANNELS x WINDOW slots before ready rises.
// Depends on wbrm_pkg, wbrm_store and wbrm_div.
module windowed_byte_rate_meter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  wbrm_pkg::t_in_word  i_in,
    output logic                o_valid,
    input  logic                i_ready,
    output wbrm_pkg::t_out_word o_out
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SWEEP,
        S_DELTA,
        S_SUM,
        S_ABS,
        S_UNIT,
        S_DIV,
        S_FINISH
    } t_state;

    t_state                               r_state;
    logic [wbrm_pkg::CH_IDX_W-1:0]        r_clr_ch;
    logic [wbrm_pkg::SLOT_W-1:0]          r_clr_slot;
    logic [wbrm_pkg::SLOT_W-1:0]          r_pos;
    logic [wbrm_pkg::FILL_W-1:0]          r_fill;
    logic [wbrm_pkg::CH_IDX_W-1:0]        r_ch;
    logic [wbrm_pkg::TOT_W-1:0]           r_total;
    logic signed [wbrm_pkg::DELTA_W-1:0]  r_delta;
    logic signed [wbrm_pkg::SUM_W-1:0]    r_sum;
    logic [wbrm_pkg::SUM_W-1:0]           r_mag;
    logic                                 r_neg;
    logic signed [wbrm_pkg::RATE_W-1:0]   r_rate;
    logic [wbrm_pkg::UNIT_W-1:0]          r_rate_unit;
    logic [wbrm_pkg::SIZE_W-1:0]          r_size_scaled;
    logic [wbrm_pkg::UNIT_W-1:0]          r_size_unit;
    logic                                 r_out_valid;
    wbrm_pkg::t_out_word                  r_out;

    wbrm_pkg::t_store_req                 w_req;
    logic [wbrm_pkg::TOT_W-1:0]           w_prev;
    logic signed [wbrm_pkg::SUM_W-1:0]    w_sum_rd;
    logic signed [wbrm_pkg::DELTA_W-1:0]  w_slot_rd;
    logic                                 w_div_start;
    logic                                 w_div_done;
    logic [wbrm_pkg::DIV_W-1:0]           w_quot;

    logic                                 w_accept;
    logic                                 w_ch_ok;
    logic [wbrm_pkg::CH_IDX_W-1:0]        w_in_ch;
    logic signed [wbrm_pkg::TOT_W:0]      n_diff;
    logic signed [wbrm_pkg::DELTA_W-1:0]  n_delta;
    logic signed [wbrm_pkg::SUM_W-1:0]    n_sum;
    logic [wbrm_pkg::SUM_W-1:0]           n_mag;
    logic                                 n_ge1;
    logic                                 n_ge2;
    logic                                 n_ge3;
    logic [wbrm_pkg::UNIT_W-1:0]          n_rate_unit;
    logic [wbrm_pkg::DIV_W-1:0]           n_dividend;
    logic [wbrm_pkg::DIV_W-1:0]           n_q_sat;
    logic [wbrm_pkg::RATE_W-1:0]          n_rate_mag;
    logic signed [wbrm_pkg::RATE_W-1:0]   n_rate;
    logic [wbrm_pkg::SIZE_W-1:0]          n_size_scaled;
    logic [wbrm_pkg::UNIT_W-1:0]          n_size_unit;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_ch_ok  = (int'(i_in.channel) < wbrm_pkg::CHANNELS);
    assign w_in_ch  = i_in.channel[wbrm_pkg::CH_IDX_W-1:0];

    // storage requests
    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_req.ch_we     = (r_clr_slot == '0);
                w_req.ch_addr   = r_clr_ch;
                w_req.slot_we   = 1'b1;
                w_req.slot_addr = {r_clr_ch, r_clr_slot};
            end
            S_IDLE: begin
                if (w_accept && w_ch_ok && (i_in.op == wbrm_pkg::OP_START)) begin
                    w_req.ch_we      = 1'b1;
                    w_req.ch_addr    = w_in_ch;
                    w_req.prev_wdata = i_in.total_bytes;
                end
                if (w_accept && w_ch_ok && (i_in.op == wbrm_pkg::OP_SAMPLE)) begin
                    w_req.ch_re     = 1'b1;
                    w_req.ch_addr   = w_in_ch;
                    w_req.slot_re   = 1'b1;
                    w_req.slot_addr = {w_in_ch, r_pos};
                end
            end
            S_SWEEP: begin
                w_req.slot_we   = 1'b1;
                w_req.slot_addr = {r_ch, r_clr_slot};
            end
            S_ABS: begin
                w_req.ch_we      = 1'b1;
                w_req.ch_addr    = r_ch;
                w_req.prev_wdata = r_total;
                w_req.sum_wdata  = r_sum;
                w_req.slot_we    = 1'b1;
                w_req.slot_addr  = {r_ch, r_pos};
                w_req.slot_wdata = r_delta;
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    wbrm_store u_store (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_prev (w_prev),
        .o_sum  (w_sum_rd),
        .o_slot (w_slot_rd)
    );

    assign w_div_start = (r_state == S_UNIT) && (r_fill != '0);

    wbrm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_dividend),
        .i_divisor  (r_fill),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // datapath steps
    always_comb begin
        n_diff = $signed({1'b0, r_total}) - $signed({1'b0, w_prev});
        if (!n_diff[wbrm_pkg::TOT_W]
            && (n_diff[wbrm_pkg::TOT_W-1:wbrm_pkg::DELTA_W-1] != '0)) begin
            n_delta = {1'b0, {(wbrm_pkg::DELTA_W-1){1'b1}}};
        end else if (n_diff[wbrm_pkg::TOT_W]
            && (n_diff[wbrm_pkg::TOT_W-1:wbrm_pkg::DELTA_W-1] != '1)) begin
            n_delta = {1'b1, {(wbrm_pkg::DELTA_W-1){1'b0}}};
        end else begin
            n_delta = n_diff[wbrm_pkg::DELTA_W-1:0];
        end

        n_sum = w_sum_rd
              - {{(wbrm_pkg::SUM_W-wbrm_pkg::DELTA_W){w_slot_rd[wbrm_pkg::DELTA_W-1]}}, w_slot_rd}
              + {{(wbrm_pkg::SUM_W-wbrm_pkg::DELTA_W){r_delta[wbrm_pkg::DELTA_W-1]}}, r_delta};

        n_mag = r_sum[wbrm_pkg::SUM_W-1] ? (-r_sum) : r_sum;

        n_ge1 = ((r_mag >> 10) >= wbrm_pkg::SUM_W'(r_fill));
        n_ge2 = ((r_mag >> 20) >= wbrm_pkg::SUM_W'(r_fill));
        n_ge3 = ((r_mag >> 30) >= wbrm_pkg::SUM_W'(r_fill));
        priority if (r_neg) begin
            n_rate_unit = wbrm_pkg::UNIT_B;
        end else if (n_ge3) begin
            n_rate_unit = wbrm_pkg::UNIT_GB;
        end else if (n_ge2) begin
            n_rate_unit = wbrm_pkg::UNIT_MB;
        end else if (n_ge1) begin
            n_rate_unit = wbrm_pkg::UNIT_KB;
        end else begin
            n_rate_unit = wbrm_pkg::UNIT_B;
        end
        unique case (n_rate_unit)
            wbrm_pkg::UNIT_KB: n_dividend = wbrm_pkg::DIV_W'(r_mag >> 2);
            wbrm_pkg::UNIT_MB: n_dividend = wbrm_pkg::DIV_W'(r_mag >> 12);
            wbrm_pkg::UNIT_GB: n_dividend = wbrm_pkg::DIV_W'(r_mag >> 22);
            default:           n_dividend = {r_mag, 8'd0};
        endcase

        if (r_neg) begin
            n_q_sat = (w_quot > wbrm_pkg::RATE_NEG_MAG) ? wbrm_pkg::RATE_NEG_MAG : w_quot;
        end else begin
            n_q_sat = (w_quot > wbrm_pkg::RATE_POS_MAX) ? wbrm_pkg::RATE_POS_MAX : w_quot;
        end
        n_rate_mag = n_q_sat[wbrm_pkg::RATE_W-1:0];
        n_rate     = r_neg ? $signed(-n_rate_mag) : $signed(n_rate_mag);

        priority if (r_total >= wbrm_pkg::TOT_W'(64'd1 << 30)) begin
            n_size_unit   = wbrm_pkg::UNIT_GB;
            n_size_scaled = wbrm_pkg::SIZE_W'(r_total >> 22);
        end else if (r_total >= wbrm_pkg::TOT_W'(64'd1 << 20)) begin
            n_size_unit   = wbrm_pkg::UNIT_MB;
            n_size_scaled = wbrm_pkg::SIZE_W'(r_total >> 12);
        end else if (r_total >= wbrm_pkg::TOT_W'(64'd1 << 10)) begin
            n_size_unit   = wbrm_pkg::UNIT_KB;
            n_size_scaled = wbrm_pkg::SIZE_W'(r_total >> 2);
        end else begin
            n_size_unit   = wbrm_pkg::UNIT_B;
            n_size_scaled = wbrm_pkg::SIZE_W'({r_total, 8'd0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_ch    <= '0;
            r_clr_slot  <= '0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_FINISH) && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_slot == wbrm_pkg::SLOT_W'(wbrm_pkg::WINDOW - 1)) begin
                        r_clr_slot <= '0;
                        r_clr_ch   <= r_clr_ch + 1'b1;
                        if (r_clr_ch == wbrm_pkg::CH_IDX_W'(wbrm_pkg::CHANNELS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_clr_slot <= r_clr_slot + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_ch    <= w_in_ch;
                        r_total <= i_in.total_bytes;
                        if (i_in.op == wbrm_pkg::OP_TICK) begin
                            r_pos <= (r_pos == wbrm_pkg::SLOT_W'(wbrm_pkg::WINDOW - 1))
                                   ? '0 : r_pos + 1'b1;
                            if (r_fill < wbrm_pkg::FILL_W'(wbrm_pkg::WINDOW)) begin
                                r_fill <= r_fill + 1'b1;
                            end
                        end else if (w_ch_ok && (i_in.op == wbrm_pkg::OP_START)) begin
                            r_clr_slot <= '0;
                            r_state    <= S_SWEEP;
                        end else if (w_ch_ok && (i_in.op == wbrm_pkg::OP_SAMPLE)) begin
                            r_state <= S_DELTA;
                        end
                    end
                end
                S_SWEEP: begin
                    if (r_clr_slot == wbrm_pkg::SLOT_W'(wbrm_pkg::WINDOW - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr_slot <= r_clr_slot + 1'b1;
                    end
                end
                S_DELTA: begin
                    r_delta <= n_delta;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= n_sum;
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_mag         <= n_mag;
                    r_neg         <= r_sum[wbrm_pkg::SUM_W-1];
                    r_size_scaled <= n_size_scaled;
                    r_size_unit   <= n_size_unit;
                    r_state       <= S_UNIT;
                end
                S_UNIT: begin
                    if (r_fill == '0) begin
                        r_rate      <= '0;
                        r_rate_unit <= wbrm_pkg::UNIT_B;
                        r_state     <= S_FINISH;
                    end else begin
                        r_rate_unit <= n_rate_unit;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_rate  <= n_rate;
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || i_ready) begin
                        r_out.rate_scaled <= r_rate;
                        r_out.rate_unit   <= r_rate_unit;
                        r_out.size_scaled <= r_size_scaled;
                        r_out.size_unit   <= r_size_unit;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule
